FILE: rtl/lbm_pkg.sv
`timescale 1ns / 1ps
package lbm_pkg;

   localparam int FRAC_BITS = 32;
   localparam int WORD_BITS = 48;
   localparam int HALF_BITS = WORD_BITS / 2;
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int QUO_BITS  = WORD_BITS + FRAC_BITS;
   localparam int NDIR      = 9;
   localparam int NOUT      = 12;

   // pipeline depths shared by the top level and the lanes
   localparam int MUL_LAT   = 2;
   localparam int DIV_STEPS = QUO_BITS / 2;
   localparam int DIV_LAT   = DIV_STEPS + 2;
   localparam int LANE_LAT  = 6 + 4 * MUL_LAT;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic [WORD_BITS-1:0]        umag_type;
   typedef logic [QUO_BITS-1:0]         mag_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam mag_type  MAG_POS  = mag_type'(WORD_MAX);
   localparam mag_type  MAG_NEG  = MAG_POS + mag_type'(1);
   localparam word_type ONE      = word_type'(64'd1 << FRAC_BITS);

   // weights rounded to nearest
   localparam logic [63:0] W_4_9  = ((64'd4 << FRAC_BITS) + 64'd4) / 64'd9;
   localparam logic [63:0] W_1_9  = ((64'd1 << FRAC_BITS) + 64'd4) / 64'd9;
   localparam logic [63:0] W_1_36 = ((64'd1 << FRAC_BITS) + 64'd18) / 64'd36;

   localparam int DIR_X [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
   localparam int DIR_Y [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
   localparam word_type WEIGHT [NDIR] = '{
      word_type'(W_4_9),
      word_type'(W_1_9), word_type'(W_1_9), word_type'(W_1_9), word_type'(W_1_9),
      word_type'(W_1_36), word_type'(W_1_36), word_type'(W_1_36), word_type'(W_1_36)};

   localparam logic [1:0] KIND_FLUID = 2'd0;
   localparam logic [1:0] KIND_WALL  = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;

   localparam logic [2:0] CSR_RELAX     = 3'd0;
   localparam logic [2:0] CSR_FORCE_X   = 3'd1;
   localparam logic [2:0] CSR_FORCE_Y   = 3'd2;
   localparam logic [2:0] CSR_SPEED     = 3'd3;
   localparam logic [2:0] CSR_INV_SPEED = 3'd4;

   function automatic word_type sat_wide(input logic signed [WORD_BITS:0] v);
      if (v[WORD_BITS] != v[WORD_BITS-1]) begin
         return v[WORD_BITS] ? WORD_MIN : WORD_MAX;
      end
      return v[WORD_BITS-1:0];
   endfunction

   function automatic word_type sat_add(input word_type a, input word_type b);
      logic signed [WORD_BITS:0] s;
      s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
      return sat_wide(s);
   endfunction

   function automatic word_type sat_sub(input word_type a, input word_type b);
      logic signed [WORD_BITS:0] s;
      s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
      return sat_wide(s);
   endfunction

   function automatic umag_type word_mag(input word_type a);
      return a[WORD_BITS-1] ? umag_type'(~a + word_type'(1)) : umag_type'(a);
   endfunction

   function automatic word_type from_mag(input mag_type m, input logic neg);
      mag_type lim;
      mag_type v;
      lim = neg ? MAG_NEG : MAG_POS;
      v   = (m > lim) ? lim : m;
      if (neg) begin
         return word_type'(~v[WORD_BITS-1:0] + umag_type'(1));
      end
      return word_type'(v[WORD_BITS-1:0]);
   endfunction

   // small constant times a, optionally halved, truncated toward zero
   function automatic word_type scale(input word_type a, input logic [3:0] k, input logic half);
      logic [WORD_BITS+3:0] m;
      m = {4'b0000, word_mag(a)} * k;
      if (half) begin
         m = m >> 1;
      end
      return from_mag(mag_type'(m), a[WORD_BITS-1]);
   endfunction

endpackage

FILE: rtl/lbm_delay.sv
`timescale 1ns / 1ps
module lbm_delay #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] stage_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            stage_ff[i] <= stage_ff[i-1];
         end
      end
   end

   assign dout = stage_ff[DEPTH-1];

endmodule

FILE: rtl/lbm_qmul.sv
`timescale 1ns / 1ps
module lbm_qmul
   import lbm_pkg::*;
(
   input  logic     clock,
   input  logic     en,
   input  word_type a,
   input  word_type b,
   output word_type p
);

   umag_type ua;
   umag_type ub;
   logic [WORD_BITS-1:0] pp00_ff, pp01_ff, pp10_ff, pp11_ff;
   logic                 neg_ff;
   logic [PROD_BITS-1:0] prod;
   mag_type              mag;
   word_type             p_ff;

   assign ua = word_mag(a);
   assign ub = word_mag(b);

   // four half-width partial products
   always_ff @(posedge clock) begin
      if (en) begin
         pp00_ff <= ua[HALF_BITS-1:0] * ub[HALF_BITS-1:0];
         pp01_ff <= ua[HALF_BITS-1:0] * ub[WORD_BITS-1:HALF_BITS];
         pp10_ff <= ua[WORD_BITS-1:HALF_BITS] * ub[HALF_BITS-1:0];
         pp11_ff <= ua[WORD_BITS-1:HALF_BITS] * ub[WORD_BITS-1:HALF_BITS];
         neg_ff  <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
      end
   end

   always_comb begin
      prod = PROD_BITS'(pp00_ff)
           + (PROD_BITS'(pp01_ff) << HALF_BITS)
           + (PROD_BITS'(pp10_ff) << HALF_BITS)
           + (PROD_BITS'(pp11_ff) << WORD_BITS);
      mag  = mag_type'(prod[PROD_BITS-1:FRAC_BITS]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= from_mag(mag, neg_ff);
      end
   end

   assign p = p_ff;

endmodule

FILE: rtl/lbm_qdiv.sv
`timescale 1ns / 1ps
module lbm_qdiv
   import lbm_pkg::*;
(
   input  logic     clock,
   input  logic     en,
   input  word_type num,
   input  word_type den,
   output word_type quo
);

   // dividend bits shift out of the top while quotient bits fill in below
   mag_type  dq_ff  [DIV_STEPS+1];
   umag_type rem_ff [DIV_STEPS];
   umag_type ud_ff  [DIV_STEPS+1];
   logic     neg_ff [DIV_STEPS+1];
   word_type quo_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         dq_ff[0]  <= mag_type'({word_mag(num), {FRAC_BITS{1'b0}}});
         rem_ff[0] <= '0;
         ud_ff[0]  <= word_mag(den);
         neg_ff[0] <= num[WORD_BITS-1] ^ den[WORD_BITS-1];
      end
   end

   for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
      logic [WORD_BITS:0] part;
      umag_type           rem_nx;
      mag_type            dq_nx;

      // two restoring steps per stage
      always_comb begin
         part   = '0;
         rem_nx = rem_ff[s-1];
         dq_nx  = dq_ff[s-1];
         for (int k = 0; k < 2; k++) begin
            part  = {rem_nx, dq_nx[QUO_BITS-1]};
            dq_nx = {dq_nx[QUO_BITS-2:0], 1'b0};
            if (part >= {1'b0, ud_ff[s-1]}) begin
               part     = part - {1'b0, ud_ff[s-1]};
               dq_nx[0] = 1'b1;
            end
            rem_nx = part[WORD_BITS-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dq_ff[s]  <= dq_nx;
            ud_ff[s]  <= ud_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
         end
      end

      if (s < DIV_STEPS) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= rem_nx;
            end
         end
      end
   end

   // a zero divisor gives zero
   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= (ud_ff[DIV_STEPS] == '0) ? '0
                 : from_mag(dq_ff[DIV_STEPS], neg_ff[DIV_STEPS]);
      end
   end

   assign quo = quo_ff;

endmodule

FILE: rtl/lbm_lane.sv
`timescale 1ns / 1ps
module lbm_lane
   import lbm_pkg::*;
#(
   parameter int DIR = 0
) (
   input  logic     clock,
   input  logic     en,
   input  word_type ux,
   input  word_type uy,
   input  word_type f,
   input  word_type rho,
   input  word_type ic,
   input  word_type ic2,
   input  word_type term3,
   input  word_type relax,
   output word_type res
);

   // term3 is presented later than ux, uy, f and rho, as the top level
   // forms it from ux and uy
   localparam word_type WGT = WEIGHT[DIR];

   word_type eu_in, eu_ff;
   word_type prod_a, prod_e2, prod_b, wr, feq, corr;
   word_type k3a_ff, k3a_d, k45b_ff, s1_ff, term3_ff, t_ff, dif_ff, res_ff;
   word_type rho_d, f_a, f_b;

   always_comb begin
      eu_in = '0;
      if (DIR_X[DIR] > 0) begin
         eu_in = sat_add(eu_in, ux);
      end else if (DIR_X[DIR] < 0) begin
         eu_in = sat_sub(eu_in, ux);
      end
      if (DIR_Y[DIR] > 0) begin
         eu_in = sat_add(eu_in, uy);
      end else if (DIR_Y[DIR] < 0) begin
         eu_in = sat_sub(eu_in, uy);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         eu_ff <= eu_in;
      end
   end

   lbm_qmul u_mul_a  (.clock(clock), .en(en), .a(eu_ff), .b(ic),    .p(prod_a));
   lbm_qmul u_mul_e2 (.clock(clock), .en(en), .a(eu_ff), .b(eu_ff), .p(prod_e2));
   lbm_qmul u_mul_b  (.clock(clock), .en(en), .a(prod_e2), .b(ic2), .p(prod_b));

   lbm_delay #(.WIDTH(WORD_BITS), .DEPTH(MUL_LAT)) u_k3a_dly (
      .clock(clock), .en(en), .din(k3a_ff), .dout(k3a_d));
   lbm_delay #(.WIDTH(WORD_BITS), .DEPTH(4 + MUL_LAT)) u_rho_dly (
      .clock(clock), .en(en), .din(rho), .dout(rho_d));
   lbm_delay #(.WIDTH(WORD_BITS), .DEPTH(4 + 3 * MUL_LAT)) u_f_dly_a (
      .clock(clock), .en(en), .din(f), .dout(f_a));
   lbm_delay #(.WIDTH(WORD_BITS), .DEPTH(1 + MUL_LAT)) u_f_dly_b (
      .clock(clock), .en(en), .din(f_a), .dout(f_b));

   lbm_qmul u_mul_w   (.clock(clock), .en(en), .a(WGT),    .b(rho_d), .p(wr));
   lbm_qmul u_mul_feq (.clock(clock), .en(en), .a(wr),     .b(t_ff),  .p(feq));
   lbm_qmul u_mul_rlx (.clock(clock), .en(en), .a(dif_ff), .b(relax), .p(corr));

   always_ff @(posedge clock) begin
      if (en) begin
         k3a_ff   <= scale(prod_a, 4'd3, 1'b0);
         k45b_ff  <= scale(prod_b, 4'd9, 1'b1);
         s1_ff    <= sat_add(k3a_d, k45b_ff);
         term3_ff <= term3;
         t_ff     <= sat_add(ONE, sat_sub(s1_ff, term3_ff));
         dif_ff   <= sat_sub(f_a, feq);
         res_ff   <= sat_sub(f_b, corr);
      end
   end

   assign res = res_ff;

endmodule

FILE: rtl/lattice_boltzmann_d2q9_collide_top.sv
`timescale 1ns / 1ps
// D2Q9 BGK collision, one lattice cell per item.
// req_*: one cell in, the nine distributions in req_tdata and the cell kind
//   in req_tuser (fluid, wall, empty). Accepted when req_tvalid and req_tready.
// rsp_*: nine post-collision distributions, density and the two velocity
//   components, one item for every cell taken in, in order.
// csr_*: register writes (relax rate, force times tau in x and y, lattice
//   speed, its reciprocal); always ready, to be written only while idle.
// Throughput: one cell per cycle while req_tready is high. The path from
//   acceptance to rsp_tvalid runs mostly through the radix-4 divider pipeline that
//   forms the velocity, followed by the 14-stage equilibrium lanes.
// Nine lanes, one per direction, run side by side; the final stage merges
//   them with density and velocity and handles empty cells.
// When the receiver stalls, the output register and a one-item skid buffer
//   hold results; req_tready drops only once the skid buffer fills, and the
//   whole pipeline then holds still.
// Reset (synchronous) empties the pipeline and the output buffer and loads
//   the registers with relax rate 1.0, zero force, speed 1.0 and 1/speed 1.0.
module lattice_boltzmann_d2q9_collide_top
   import lbm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // dist_rest, dist_east, dist_north, dist_west, dist_south,
   // dist_northeast, dist_northwest, dist_southwest, dist_southeast
   input  logic [431:0] req_tdata,
   // cell_kind
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // new_rest, new_east, new_north, new_west, new_south, new_northeast,
   // new_northwest, new_southwest, new_southeast, density, velocity_x, velocity_y
   output logic [575:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [47:0]  csr_data
);

   localparam int VEC_BITS = NDIR * WORD_BITS;
   localparam int OUT_BITS = NOUT * WORD_BITS;
   localparam int V_SLOT   = 3 + MUL_LAT + DIV_LAT;
   localparam int U_SLOT   = V_SLOT + 1;
   localparam int PIPE_LAT = U_SLOT + LANE_LAT + 1;

   typedef struct packed {
      word_type rho;
      word_type mx;
      word_type my;
   } acc_type;

   function automatic acc_type acc_run(input acc_type acc_i,
                                       input logic [VEC_BITS-1:0] vec,
                                       input int first);
      acc_type  acc;
      word_type fq;
      int       q;
      acc = acc_i;
      for (int k = 0; k < 3; k++) begin
         q  = first + k;
         fq = vec[q*WORD_BITS +: WORD_BITS];
         acc.rho = sat_add(acc.rho, fq);
         if (DIR_X[q] > 0) begin
            acc.mx = sat_add(acc.mx, fq);
         end else if (DIR_X[q] < 0) begin
            acc.mx = sat_sub(acc.mx, fq);
         end
         if (DIR_Y[q] > 0) begin
            acc.my = sat_add(acc.my, fq);
         end else if (DIR_Y[q] < 0) begin
            acc.my = sat_sub(acc.my, fq);
         end
      end
      return acc;
   endfunction

   // configuration registers
   logic [33:0] relax_ff;
   word_type    force_x_ff, force_y_ff;
   logic [46:0] speed_ff, inv_speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         relax_ff     <= 34'h1_0000_0000;
         force_x_ff   <= '0;
         force_y_ff   <= '0;
         speed_ff     <= 47'h1_0000_0000;
         inv_speed_ff <= 47'h1_0000_0000;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_RELAX:     relax_ff     <= csr_data[33:0];
            CSR_FORCE_X:   force_x_ff   <= csr_data;
            CSR_FORCE_Y:   force_y_ff   <= csr_data;
            CSR_SPEED:     speed_ff     <= csr_data[46:0];
            CSR_INV_SPEED: inv_speed_ff <= csr_data[46:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   word_type relax_w, speed_w, inv_speed_w;
   assign relax_w     = word_type'(relax_ff);
   assign speed_w     = word_type'(speed_ff);
   assign inv_speed_w = word_type'(inv_speed_ff);

   // pipeline control
   logic                  en;
   logic [PIPE_LAT:1]     valid_ff;
   logic                  skid_valid_ff;

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[PIPE_LAT-1:1], req_tvalid};
      end
   end

   // moment sums, three directions per stage
   logic [VEC_BITS-1:0] f1_ff, f2_ff;
   logic [1:0]          kind1_ff, kind2_ff;
   acc_type             acc1_ff, acc2_ff, acc3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         f1_ff    <= req_tdata;
         kind1_ff <= req_tuser;
         acc1_ff  <= acc_run('0, req_tdata, 0);
         f2_ff    <= f1_ff;
         kind2_ff <= kind1_ff;
         acc2_ff  <= acc_run(acc1_ff, f1_ff, 3);
         acc3_ff  <= acc_run(acc2_ff, f2_ff, 6);
      end
   end

   // velocity = c * m / rho
   word_type mxc, myc, rho_div, vx, vy;

   lbm_qmul u_mul_mx (.clock(clock), .en(en), .a(acc3_ff.mx), .b(speed_w), .p(mxc));
   lbm_qmul u_mul_my (.clock(clock), .en(en), .a(acc3_ff.my), .b(speed_w), .p(myc));
   lbm_delay #(.WIDTH(WORD_BITS), .DEPTH(MUL_LAT)) u_rho_div_dly (
      .clock(clock), .en(en), .din(acc3_ff.rho), .dout(rho_div));
   lbm_qdiv u_div_x (.clock(clock), .en(en), .num(mxc), .den(rho_div), .quo(vx));
   lbm_qdiv u_div_y (.clock(clock), .en(en), .num(myc), .den(rho_div), .quo(vy));

   logic [1:0] kind_v, kind_m;
   lbm_delay #(.WIDTH(2), .DEPTH(V_SLOT - 2)) u_kind_dly_v (
      .clock(clock), .en(en), .din(kind2_ff), .dout(kind_v));
   lbm_delay #(.WIDTH(2), .DEPTH(LANE_LAT + 1)) u_kind_dly_m (
      .clock(clock), .en(en), .din(kind_v), .dout(kind_m));

   // fluid cells are shifted by the body force
   word_type ux_ff, uy_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         ux_ff <= (kind_v == KIND_FLUID) ? sat_add(vx, force_x_ff) : vx;
         uy_ff <= (kind_v == KIND_FLUID) ? sat_add(vy, force_y_ff) : vy;
      end
   end

   logic [VEC_BITS-1:0] f_u, f_m;
   word_type            rho_u, rho_m, vx_m, vy_m;

   lbm_delay #(.WIDTH(VEC_BITS), .DEPTH(U_SLOT - 2)) u_f_dly_u (
      .clock(clock), .en(en), .din(f2_ff), .dout(f_u));
   lbm_delay #(.WIDTH(VEC_BITS), .DEPTH(LANE_LAT)) u_f_dly_m (
      .clock(clock), .en(en), .din(f_u), .dout(f_m));
   lbm_delay #(.WIDTH(WORD_BITS), .DEPTH(U_SLOT - 3)) u_rho_dly_u (
      .clock(clock), .en(en), .din(acc3_ff.rho), .dout(rho_u));
   lbm_delay #(.WIDTH(WORD_BITS), .DEPTH(LANE_LAT)) u_rho_dly_m (
      .clock(clock), .en(en), .din(rho_u), .dout(rho_m));
   lbm_delay #(.WIDTH(WORD_BITS), .DEPTH(LANE_LAT + 1)) u_vx_dly_m (
      .clock(clock), .en(en), .din(vx), .dout(vx_m));
   lbm_delay #(.WIDTH(WORD_BITS), .DEPTH(LANE_LAT + 1)) u_vy_dly_m (
      .clock(clock), .en(en), .din(vy), .dout(vy_m));

   // shared terms: ic^2 (static between writes) and 1.5 * u.u * ic^2
   word_type ic2, ux2, uy2, uu_ff, uuic, term3_ff;

   lbm_qmul u_mul_ic2 (.clock(clock), .en(en), .a(inv_speed_w), .b(inv_speed_w), .p(ic2));
   lbm_qmul u_mul_ux2 (.clock(clock), .en(en), .a(ux_ff), .b(ux_ff), .p(ux2));
   lbm_qmul u_mul_uy2 (.clock(clock), .en(en), .a(uy_ff), .b(uy_ff), .p(uy2));
   lbm_qmul u_mul_uu  (.clock(clock), .en(en), .a(uu_ff), .b(ic2),   .p(uuic));

   always_ff @(posedge clock) begin
      if (en) begin
         uu_ff    <= sat_add(ux2, uy2);
         term3_ff <= scale(uuic, 4'd3, 1'b1);
      end
   end

   word_type lane_res [NDIR];

   for (genvar q = 0; q < NDIR; q++) begin : g_lane
      lbm_lane #(.DIR(q)) u_lane (
         .clock (clock),
         .en    (en),
         .ux    (ux_ff),
         .uy    (uy_ff),
         .f     (f_u[q*WORD_BITS +: WORD_BITS]),
         .rho   (rho_u),
         .ic    (inv_speed_w),
         .ic2   (ic2),
         .term3 (term3_ff),
         .relax (relax_w),
         .res   (lane_res[q])
      );
   end

   // merge lanes with the moments; empty cells pass through
   logic [OUT_BITS-1:0] merge_in, merge_ff;
   logic                empty_m;

   assign empty_m = (kind_m != KIND_FLUID) && (kind_m != KIND_WALL);

   always_comb begin
      merge_in = '0;
      for (int q = 0; q < NDIR; q++) begin
         merge_in[q*WORD_BITS +: WORD_BITS] =
            empty_m ? f_m[q*WORD_BITS +: WORD_BITS] : lane_res[q];
      end
      if (!empty_m) begin
         merge_in[NDIR*WORD_BITS +: WORD_BITS]     = rho_m;
         merge_in[(NDIR+1)*WORD_BITS +: WORD_BITS] = vx_m;
         merge_in[(NDIR+2)*WORD_BITS +: WORD_BITS] = vy_m;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         merge_ff <= merge_in;
      end
   end

   // output register plus skid buffer
   logic                rsp_valid_ff, rsp_valid_in, skid_valid_in;
   logic [OUT_BITS-1:0] rsp_data_ff, rsp_data_in, skid_data_ff, skid_data_in;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (en && valid_ff[PIPE_LAT]) begin
         if (rsp_valid_ff && !rsp_tready) begin
            skid_valid_in = 1'b1;
            skid_data_in  = merge_ff;
         end else begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = merge_ff;
         end
      end else if (rsp_tready) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
module testbench
   import lbm_pkg::*;
();

   typedef logic signed [127:0] wide_type;

   localparam longint QMAX = (64'sd1 <<< 47) - 1;
   localparam longint QMIN = -(64'sd1 <<< 47);
   localparam longint Q_ONE = 64'sd1 <<< 32;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 80;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [2:0] CSR_UNMAPPED = 3'd5;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [431:0] req_tdata = '0;
   logic [1:0] req_tuser = KIND_FLUID;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [575:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = CSR_RELAX;
   logic [47:0] csr_data = '0;

   lattice_boltzmann_d2q9_collide_top uut (.*);

   always #1 clock = ~clock;

   // register shadows
   longint relax_q = Q_ONE;
   longint force_x_q = 0;
   longint force_y_q = 0;
   longint speed_q = Q_ONE;
   longint inv_speed_q = Q_ONE;

   logic [575:0] pending_cells[$];
   int errors = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int recv_hold = 0;

   const int dx[9] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
   const int dy[9] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
   const longint wnum[9] = '{4, 1, 1, 1, 1, 1, 1, 1, 1};
   const longint wden[9] = '{9, 9, 9, 9, 9, 36, 36, 36, 36};
   const string out_names[12] = '{"new_rest", "new_east", "new_north", "new_west",
      "new_south", "new_northeast", "new_northwest", "new_southwest", "new_southeast",
      "density", "velocity_x", "velocity_y"};

   function automatic longint clamp_q(wide_type v);
      if (v > wide_type'(QMAX)) return QMAX;
      if (v < wide_type'(QMIN)) return QMIN;
      return longint'(v);
   endfunction

   function automatic longint add_q(longint a, longint b);
      return clamp_q(wide_type'(a) + wide_type'(b));
   endfunction

   function automatic longint sub_q(longint a, longint b);
      return clamp_q(wide_type'(a) - wide_type'(b));
   endfunction

   function automatic longint mul_q(longint a, longint b);
      wide_type p;
      p = wide_type'(a) * wide_type'(b);
      if (p < 0) p = -((-p) >>> 32);
      else p = p >>> 32;
      return clamp_q(p);
   endfunction

   function automatic longint div_q(longint n, longint d);
      if (d == 0) return 0;
      return clamp_q((wide_type'(n) <<< 32) / wide_type'(d));
   endfunction

   function automatic longint sext48(logic [47:0] v);
      return longint'(signed'(v));
   endfunction

   function automatic logic [575:0] collide_cell(logic [1:0] kind, logic [431:0] cell_vec);
      longint f[9];
      longint res[12];
      longint rho, mx, my, vx, vy, ux, uy, ic2, uu, t3, eu, s, feq, w;
      logic [575:0] packed_out;
      rho = 0; mx = 0; my = 0; vx = 0; vy = 0;
      for (int q = 0; q < 9; q++) f[q] = sext48(cell_vec[48*q +: 48]);
      if (kind == KIND_EMPTY || kind == KIND_UNUSED) begin
         for (int q = 0; q < 9; q++) res[q] = f[q];
         res[9] = 0; res[10] = 0; res[11] = 0;
      end else begin
         for (int q = 0; q < 9; q++) begin
            rho = add_q(rho, f[q]);
            if (dx[q] > 0) mx = add_q(mx, f[q]);
            if (dx[q] < 0) mx = sub_q(mx, f[q]);
            if (dy[q] > 0) my = add_q(my, f[q]);
            if (dy[q] < 0) my = sub_q(my, f[q]);
         end
         if (rho != 0) begin
            vx = div_q(mul_q(mx, speed_q), rho);
            vy = div_q(mul_q(my, speed_q), rho);
         end
         ux = vx; uy = vy;
         if (kind == KIND_FLUID) begin
            ux = add_q(vx, force_x_q);
            uy = add_q(vy, force_y_q);
         end
         ic2 = mul_q(inv_speed_q, inv_speed_q);
         uu = add_q(mul_q(ux, ux), mul_q(uy, uy));
         t3 = mul_q(64'sd3 <<< 31, mul_q(uu, ic2));
         for (int q = 0; q < 9; q++) begin
            eu = 0;
            if (dx[q] > 0) eu = add_q(eu, ux);
            if (dx[q] < 0) eu = sub_q(eu, ux);
            if (dy[q] > 0) eu = add_q(eu, uy);
            if (dy[q] < 0) eu = sub_q(eu, uy);
            s = add_q(mul_q(64'sd3 <<< 32, mul_q(eu, inv_speed_q)),
                      mul_q(64'sd9 <<< 31, mul_q(mul_q(eu, eu), ic2)));
            s = sub_q(s, t3);
            w = ((wnum[q] <<< 32) + wden[q] / 2) / wden[q];
            feq = mul_q(mul_q(w, rho), add_q(Q_ONE, s));
            res[q] = sub_q(f[q], mul_q(sub_q(f[q], feq), relax_q));
         end
         res[9] = rho; res[10] = vx; res[11] = vy;
      end
      for (int q = 0; q < 12; q++) packed_out[48*q +: 48] = res[q][47:0];
      return packed_out;
   endfunction

   // receiver: random stalls, or a long hold when asked
   always @(posedge clock) begin
      if (recv_hold > 0) begin
         recv_hold <= recv_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_cells.size() == 0) begin
            $error("result item with nothing expected");
            errors++;
         end else begin
            logic [575:0] want;
            want = pending_cells.pop_front();
            for (int k = 0; k < 12; k++)
               if (rsp_tdata[48*k +: 48] !== want[48*k +: 48]) begin
                  $error("%s: expected %h, got %h", out_names[k],
                         want[48*k +: 48], rsp_tdata[48*k +: 48]);
                  errors++;
               end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_cell(logic [1:0] kind, logic [431:0] cell_vec);
      // idle cycle by cycle with the given odds
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= cell_vec;
      req_tuser <= kind;
      do @(posedge clock); while (!req_tready);
      pending_cells.push_back(collide_cell(kind, cell_vec));
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // leaves csr_valid high; the caller drops it after its last write
   task automatic write_csr(logic [2:0] idx, logic [47:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_RELAX:     relax_q = longint'(value[33:0]);
         CSR_FORCE_X:   force_x_q = sext48(value);
         CSR_FORCE_Y:   force_y_q = sext48(value);
         CSR_SPEED:     speed_q = longint'(value[46:0]);
         CSR_INV_SPEED: inv_speed_q = longint'(value[46:0]);
         default: ;
      endcase
   endtask

   task automatic set_regs(longint relax, longint fx, longint fy, longint c, longint ic);
      write_csr(CSR_RELAX, relax[47:0]);
      write_csr(CSR_FORCE_X, fx[47:0]);
      write_csr(CSR_FORCE_Y, fy[47:0]);
      write_csr(CSR_SPEED, c[47:0]);
      write_csr(CSR_INV_SPEED, ic[47:0]);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [47:0] rand48();
      return 48'({$urandom, $urandom});
   endfunction

   function automatic logic [1:0] rand_kind();
      int r;
      r = $urandom_range(99);
      if (r < 45) return KIND_FLUID;
      if (r < 85) return KIND_WALL;
      if (r < 95) return KIND_EMPTY;
      return KIND_UNUSED;
   endfunction

   // mostly near-equilibrium cells, some noise, zero-density and extreme cells
   function automatic logic [431:0] rand_cell();
      logic [431:0] cell_vec;
      longint rho0, v, sum;
      int mode;
      mode = $urandom_range(99);
      sum = 0;
      for (int q = 0; q < 9; q++) begin
         if (mode < 70) begin
            rho0 = longint'($urandom_range(32'hFFFF_FFFF, 32'h2000_0000));
            v = rho0 * wnum[q] / wden[q] + longint'($urandom_range(1 << 27)) - (1 << 26);
         end else if (mode < 85) begin
            v = sext48(rand48());
         end else if (mode < 93) begin
            v = longint'($urandom_range(1 << 30)) - (1 << 29);
         end else begin
            v = $urandom_range(1) ? QMAX : QMIN;
         end
         sum += v;
         cell_vec[48*q +: 48] = v[47:0];
      end
      // zero density: rest direction cancels the others
      if (mode >= 85 && mode < 93) begin
         v = cell_vec[47:0];
         v = sext48(v[47:0]) - sum;
         cell_vec[47:0] = v[47:0];
      end
      return cell_vec;
   endfunction

   function automatic logic [431:0] fill_cell(logic [47:0] v);
      logic [431:0] cell_vec;
      for (int q = 0; q < 9; q++) cell_vec[48*q +: 48] = v;
      return cell_vec;
   endfunction

   task automatic test_directed;
      logic [431:0] cell_vec;
      logic [1:0] kinds[4];
      kinds = '{KIND_FLUID, KIND_WALL, KIND_EMPTY, KIND_UNUSED};
      send_idle_pct = 0;
      recv_idle_pct = 0;
      foreach (kinds[k]) begin
         send_cell(kinds[k], fill_cell(48'h0));
         send_cell(kinds[k], fill_cell(48'h7FFF_FFFF_FFFF));
         send_cell(kinds[k], fill_cell(48'h8000_0000_0000));
      end
      send_cell(KIND_FLUID, fill_cell(48'hAAAA_AAAA_AAAA));
      send_cell(KIND_WALL, fill_cell(48'h5555_5555_5555));
      send_cell(KIND_EMPTY, fill_cell(48'hFFFF_FFFF_FFFF));
      // fluid at rest, unit density
      for (int q = 0; q < 9; q++) cell_vec[48*q +: 48] = 48'((Q_ONE * wnum[q]) / wden[q]);
      send_cell(KIND_FLUID, cell_vec);
      send_cell(KIND_WALL, cell_vec);
      // zero density with momentum
      cell_vec = '0;
      cell_vec[48*1 +: 48] = 48'(Q_ONE);
      cell_vec[48*3 +: 48] = 48'(-Q_ONE);
      send_cell(KIND_FLUID, cell_vec);
      send_cell(KIND_WALL, cell_vec);
      // strong x flow
      cell_vec = fill_cell(48'h0000_1000_0000);
      cell_vec[48*1 +: 48] = 48'h0002_0000_0000;
      send_cell(KIND_FLUID, cell_vec);
      drain();
   endtask

   task automatic test_config_sweep;
      longint mask34;
      mask34 = (64'sd1 <<< 34) - 1;
      send_idle_pct = 10;
      recv_idle_pct = 10;
      // extremes: all zero, then all at their top but force_y at its bottom
      set_regs(0, 0, 0, 0, 0);
      repeat (25) send_cell(rand_kind(), rand_cell());
      drain();
      set_regs(mask34, QMAX, QMIN, QMAX, QMAX);
      repeat (25) send_cell(rand_kind(), rand_cell());
      drain();
      set_regs(64'sd1 <<< 33, QMIN, QMAX, Q_ONE, Q_ONE);
      repeat (25) send_cell(rand_kind(), rand_cell());
      drain();
      // typical flow: tau near 0.6, small body force
      set_regs(64'sd7301444403, 64'sd429497, -64'sd858993, Q_ONE, Q_ONE);
      repeat (25) send_cell(rand_kind(), rand_cell());
      drain();
      set_regs(64'sd6442450944, -64'sd4294967, 64'sd2147483, 2 * Q_ONE, Q_ONE / 2);
      repeat (25) send_cell(rand_kind(), rand_cell());
      drain();
      // unmapped indexes leave the registers alone
      for (int k = 0; k < 3; k++) write_csr(3'(CSR_UNMAPPED + k), rand48());
      write_csr(CSR_RELAX, rand48());
      write_csr(CSR_FORCE_X, 48'({$urandom_range(1 << 24)}) - 48'(1 << 23));
      write_csr(CSR_FORCE_Y, 48'({$urandom_range(1 << 24)}) - 48'(1 << 23));
      csr_valid <= 1'b0;
      @(posedge clock);
      repeat (25) send_cell(rand_kind(), rand_cell());
      drain();
      set_regs(64'sd5153960755, 64'sd2147483, 64'sd0, Q_ONE, Q_ONE);
   endtask

   task automatic test_random_traffic;
      send_idle_pct = 29;
      recv_idle_pct = 80;
      repeat (60) send_cell(rand_kind(), rand_cell());
      send_idle_pct = 80;
      recv_idle_pct = 29;
      repeat (60) send_cell(rand_kind(), rand_cell());
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (60) send_cell(rand_kind(), rand_cell());
      drain();
   endtask

   task automatic test_backpressure;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      recv_hold = 300;
      repeat (100) send_cell(rand_kind(), rand_cell());
      // sender waits for every result before going on
      drain();
      repeat (20) send_cell(rand_kind(), rand_cell());
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_sweep();
      test_random_traffic();
      test_backpressure();
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: lattice_boltzmann_d2q9_collide_top.f
rtl/lbm_pkg.sv
rtl/lbm_delay.sv
rtl/lbm_qmul.sv
rtl/lbm_qdiv.sv
rtl/lbm_lane.sv
rtl/lattice_boltzmann_d2q9_collide_top.sv
dv/testbench.sv
